### rtl/cet_summer_time_offset_defines.svh
// Assertion macros shared by the year search and top-level RTL files.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef CET_SUMMER_TIME_OFFSET_DEFINES_SVH
`define CET_SUMMER_TIME_OFFSET_DEFINES_SVH

// Implication checked in the same cycle.
`define CSO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle.
`define CSO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cso_pkg.sv
package cso_pkg;

  // Day split: seconds / 86400 = (seconds >> 7) / 675, done by reciprocal
  localparam int unsigned SecShift   = 7;
  localparam int unsigned RecipShift = 35;
  localparam logic [25:0] RecipMul   = 26'd50903317;  // ceil(2^35 / 675)
  localparam logic [16:0] SecPerDay  = 17'd86400;

  // Bound times of day, in seconds
  localparam logic [16:0] SecOneHour   = 17'd3600;
  localparam logic [16:0] SecTwoHours  = 17'd7200;
  localparam logic [16:0] SecThreeHours = 17'd10800;

  // Offset codes, three-bit two's complement
  localparam logic [2:0] OffPlusOne  = 3'b001;
  localparam logic [2:0] OffPlusTwo  = 3'b010;
  localparam logic [2:0] OffMinusOne = 3'b111;
  localparam logic [2:0] OffMinusTwo = 3'b110;

  // Years 1970 through 2106 are indexed 0 through 136
  localparam int unsigned YearCount = 137;
  localparam int unsigned LastLeapIdx = 130;  // 2100 is not a leap year

  typedef logic [15:0] day_tab_t  [256];
  typedef logic [7:0]  idx_tab_t  [256];

  // Payload after the day split
  typedef struct packed {
    logic        mode;
    logic [31:0] ts;
    logic [15:0] days;
    logic [31:0] day_secs;
  } split_t;

  // Payload after the year search
  typedef struct packed {
    logic        mode;
    logic [15:0] days;
    logic [16:0] sod;
    logic [7:0]  yidx;
  } year_t;

  function automatic int is_leap(int k);
    int y;
    y = 1970 + k;
    return ((y % 4) == 0 && y != 2100) ? 1 : 0;
  endfunction

  // Day count of January 1st of year index k
  function automatic int year_start(int k);
    return 365 * k + (k + 1) / 4 - ((k > LastLeapIdx) ? 1 : 0);
  endfunction

  function automatic int year_index(int d);
    int k;
    k = 0;
    while (k < YearCount && year_start(k + 1) <= d) k++;
    return k;
  endfunction

  // Last Sunday of the month whose 31st lies doy31 days into the year
  function automatic int last_sunday(int k, int doy31);
    int d31;
    d31 = year_start(k) + doy31 + is_leap(k);
    return d31 - ((d31 + 4) % 7);
  endfunction

  function automatic idx_tab_t build_bucket_year();
    idx_tab_t t;
    for (int b = 0; b < 256; b++) t[b] = 8'(year_index(b * 256));
    return t;
  endfunction

  function automatic day_tab_t build_bucket_next();
    day_tab_t t;
    for (int b = 0; b < 256; b++) t[b] = 16'(year_start(year_index(b * 256) + 1));
    return t;
  endfunction

  function automatic day_tab_t build_sunday(int doy31);
    day_tab_t t;
    for (int k = 0; k < 256; k++) t[k] = 16'(last_sunday(k, doy31));
    return t;
  endfunction

  // Indexed by day count bits [15:8]: year of the bucket start, next new year
  localparam idx_tab_t BucketYear = build_bucket_year();
  localparam day_tab_t BucketNext = build_bucket_next();
  // Indexed by year: last Sunday of March and of October
  localparam day_tab_t MarSunday  = build_sunday(89);
  localparam day_tab_t OctSunday  = build_sunday(303);

endpackage

### rtl/cso_day_split.sv
module cso_day_split (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [31:0]          ts_i,
  input  logic                 mode_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output cso_pkg::split_t      data_o
);

  logic        s1_valid_q;
  logic [31:0] s1_ts_q;
  logic        s1_mode_q;
  logic [50:0] s1_prod_q;
  logic        s1_ready;
  logic        s2_valid_q;
  logic        s2_ready;
  cso_pkg::split_t s2_data_q, s2_data_d;
  logic [15:0] days;
  logic [32:0] day_prod;

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;

  // Stage 1: reciprocal multiply of seconds / 128
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      s1_ts_q   <= ts_i;
      s1_mode_q <= mode_i;
      s1_prod_q <= 51'(ts_i[31:cso_pkg::SecShift]) * 51'(cso_pkg::RecipMul);
    end
  end

  // Stage 2: day count and its start in seconds
  assign days     = s1_prod_q[cso_pkg::RecipShift +: 16];
  assign day_prod = 33'(days) * 33'(cso_pkg::SecPerDay);

  always_comb begin
    s2_data_d.mode     = s1_mode_q;
    s2_data_d.ts       = s1_ts_q;
    s2_data_d.days     = days;
    s2_data_d.day_secs = day_prod[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_data_q <= s2_data_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign data_o  = s2_data_q;

endmodule

### rtl/cso_year_find.sv
`include "cet_summer_time_offset_defines.svh"

module cso_year_find (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  cso_pkg::split_t  data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output cso_pkg::year_t   data_o
);

  logic           valid_q;
  cso_pkg::year_t data_q, data_d;
  logic [7:0]     base_idx;
  logic [15:0]    next_start;
  logic [31:0]    sod_full;

  assign ready_o = !valid_q || ready_i;

  // Second of day and year index from the bucket table
  assign base_idx   = cso_pkg::BucketYear[data_i.days[15:8]];
  assign next_start = cso_pkg::BucketNext[data_i.days[15:8]];
  assign sod_full   = data_i.ts - data_i.day_secs;

  always_comb begin
    data_d.mode = data_i.mode;
    data_d.days = data_i.days;
    data_d.sod  = sod_full[16:0];
    data_d.yidx = base_idx + 8'(data_i.days >= next_start);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  `CSO_ASSERT_IMP(a_sod_range, valid_q, data_q.sod < cso_pkg::SecPerDay, "second of day out of range")
  `CSO_ASSERT_IMP(a_year_range, valid_q, data_q.yidx < 8'(cso_pkg::YearCount), "year index out of range")
  `CSO_ASSERT_NEXT(a_hold, valid_q && !ready_i, valid_q && $stable(data_q), "stalled item changed")

endmodule

### rtl/cso_dst_decide.sv
module cso_dst_decide (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  cso_pkg::year_t   data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [2:0]       offset_hours_o,
  output logic             summer_time_o
);

  logic        valid_q;
  logic [2:0]  offset_q, offset_d;
  logic        summer_q, summer_d;
  logic [15:0] mar_day, oct_day;
  logic [16:0] begin_sec, end_sec;
  logic        after_begin, before_end;

  assign ready_o = !valid_q || ready_i;

  // Compare day and second of day against both bounds
  assign mar_day   = cso_pkg::MarSunday[data_i.yidx];
  assign oct_day   = cso_pkg::OctSunday[data_i.yidx];
  assign begin_sec = data_i.mode ? cso_pkg::SecTwoHours : cso_pkg::SecOneHour;
  assign end_sec   = data_i.mode ? cso_pkg::SecThreeHours : cso_pkg::SecOneHour;

  always_comb begin
    after_begin = (data_i.days > mar_day) ||
                  ((data_i.days == mar_day) && (data_i.sod >= begin_sec));
    before_end  = (data_i.days < oct_day) ||
                  ((data_i.days == oct_day) && (data_i.sod < end_sec));
    summer_d    = after_begin && before_end;
    case ({data_i.mode, summer_d})
      2'b00:   offset_d = cso_pkg::OffPlusOne;
      2'b01:   offset_d = cso_pkg::OffPlusTwo;
      2'b10:   offset_d = cso_pkg::OffMinusOne;
      default: offset_d = cso_pkg::OffMinusTwo;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      offset_q <= offset_d;
      summer_q <= summer_d;
    end
  end

  assign valid_o        = valid_q;
  assign offset_hours_o = offset_q;
  assign summer_time_o  = summer_q;

endmodule

### rtl/cet_summer_time_offset.sv
// Results pass through four register stages (reciprocal multiply,
// day-start product, year table search, bound compare and output register).
// Throughput: one item per cycle while the output is not stalled.
// A stalled output holds every stage upstream; nothing is dropped.
// Reset (rst_ni low, asynchronous) empties all stages; no other state.
`include "cet_summer_time_offset_defines.svh"

module cet_summer_time_offset (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] timestamp_seconds_i,
  input  logic        mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  offset_hours_o,
  output logic        summer_time_o
);

  logic            split_valid, split_ready;
  cso_pkg::split_t split_data;
  logic            year_valid, year_ready;
  cso_pkg::year_t  year_data;

  // Split seconds into days and the day's start in seconds
  cso_day_split u_day_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .ts_i    (timestamp_seconds_i),
    .mode_i  (mode_i),
    .valid_o (split_valid),
    .ready_i (split_ready),
    .data_o  (split_data)
  );

  // Find the calendar year
  cso_year_find u_year_find (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .ready_o (split_ready),
    .data_i  (split_data),
    .valid_o (year_valid),
    .ready_i (year_ready),
    .data_o  (year_data)
  );

  // Check the summer time bounds
  cso_dst_decide u_dst_decide (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (year_valid),
    .ready_o        (year_ready),
    .data_i         (year_data),
    .valid_o        (out_valid_o),
    .ready_i        (out_ready_i),
    .offset_hours_o (offset_hours_o),
    .summer_time_o  (summer_time_o)
  );

  `CSO_ASSERT_IMP(a_ready_flow, out_ready_i, in_ready_o, "input blocked while output drains")
  `CSO_ASSERT_IMP(a_summer_off, out_valid_o && summer_time_o, (offset_hours_o == cso_pkg::OffPlusTwo) || (offset_hours_o == cso_pkg::OffMinusTwo), "summer offset wrong")
  `CSO_ASSERT_IMP(a_winter_off, out_valid_o && !summer_time_o, (offset_hours_o == cso_pkg::OffPlusOne) || (offset_hours_o == cso_pkg::OffMinusOne), "standard offset wrong")

endmodule

### test/cet_summer_time_offset_checker.sv
module cet_summer_time_offset_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] timestamp_seconds_i,
  input  logic        mode_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  offset_hours_i,
  input  logic        summer_time_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned summer_results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Day count from 0000-03-01 to 1970-01-01, and days in a 400-year cycle
  localparam longint unsigned CivilShift = 719468;
  localparam longint unsigned DaysPerEra = 146097;
  localparam int unsigned     ReportLimit = 10;

  typedef struct packed {
    logic [31:0] ts;
    logic        mode;
    logic [2:0]  offset_hours;
    logic        summer_time;
  } zone_t;

  zone_t       zone_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned summer_cnt = 0;

  // Calendar year of a day count since 1970-01-01
  function automatic longint unsigned civil_year(longint unsigned day_cnt);
    longint unsigned z, era, doe, yoe, doy, mp, yr;
    z   = day_cnt + CivilShift;
    era = z / DaysPerEra;
    doe = z - era * DaysPerEra;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    yr  = yoe + era * 400;
    // January and February count toward the following year
    if (mp >= 10) yr++;
    return yr;
  endfunction

  // Day count of the last Sunday of a 31-day month from March on
  function automatic longint unsigned last_sunday(longint unsigned yr,
                                                  longint unsigned mon);
    longint unsigned era, yoe, doy, doe, d31;
    era = yr / 400;
    yoe = yr - era * 400;
    doy = (153 * (mon - 3) + 2) / 5 + 30;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    d31 = era * DaysPerEra + doe - CivilShift;
    // 1970-01-01 was a Thursday, so weekday 0 is Sunday
    return d31 - (d31 + 4) % 7;
  endfunction

  // Work out the zone offset and summer flag of one timestamp
  function automatic zone_t predict_zone(logic [31:0] ts, logic m);
    zone_t           z;
    longint unsigned secs, yr, start_s, stop_s;
    secs    = ts;
    yr      = civil_year(secs / cso_pkg::SecPerDay);
    start_s = last_sunday(yr, 3) * cso_pkg::SecPerDay;
    stop_s  = last_sunday(yr, 10) * cso_pkg::SecPerDay;
    if (m) begin
      start_s += cso_pkg::SecTwoHours;
      stop_s  += cso_pkg::SecThreeHours;
    end else begin
      start_s += cso_pkg::SecOneHour;
      stop_s  += cso_pkg::SecOneHour;
    end
    // Bounds beyond 32 bits in 2106 leave the whole range standard time
    z.ts          = ts;
    z.mode        = m;
    z.summer_time = (secs >= start_s) && (secs < stop_s);
    if (m) z.offset_hours = z.summer_time ? cso_pkg::OffMinusTwo : cso_pkg::OffMinusOne;
    else   z.offset_hours = z.summer_time ? cso_pkg::OffPlusTwo : cso_pkg::OffPlusOne;
    return z;
  endfunction

  task automatic flag(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= ReportLimit) $display("%0t ns: %s", $realtime, msg);
  endtask

  // Queue a prediction per accepted item, compare each accepted result
  always @(posedge clk_i or negedge rst_ni) begin : watch
    zone_t want;
    if (!rst_ni) begin
      zone_q.delete();
      mismatches_o     <= 0;
      pending_o        <= 0;
      results_o        <= 0;
      summer_results_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        zone_q.push_back(predict_zone(timestamp_seconds_i, mode_i));
      end
      if (out_valid_i && out_ready_i) begin
        result_cnt++;
        if (summer_time_i) summer_cnt++;
        if (zone_q.size() == 0) begin
          flag($sformatf("result with no item pending: offset %0d summer %0b",
                         $signed(offset_hours_i), summer_time_i));
        end else begin
          want = zone_q.pop_front();
          if (offset_hours_i !== want.offset_hours) begin
            flag($sformatf("ts %0d mode %0b: offset_hours expected %0d, got %0d",
                           want.ts, want.mode, $signed(want.offset_hours),
                           $signed(offset_hours_i)));
          end
          if (summer_time_i !== want.summer_time) begin
            flag($sformatf("ts %0d mode %0b: summer_time expected %0b, got %0b",
                           want.ts, want.mode, want.summer_time, summer_time_i));
          end
        end
      end
      mismatches_o     <= mismatch_cnt;
      pending_o        <= zone_q.size();
      results_o        <= result_cnt;
      summer_results_o <= summer_cnt;
    end
  end

endmodule

### test/cet_summer_time_offset_tb.sv
module cet_summer_time_offset_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 750;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 16;
  localparam longint      DaySecs     = 86400;
  localparam longint      MaxStamp    = 64'hFFFF_FFFF;

  typedef enum int unsigned {SpringUtc, AutumnUtc, SpringLocal, AutumnLocal} bound_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] timestamp_seconds = '0;
  logic        mode = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  offset_hours;
  logic        summer_time;

  logic        hold_off = 1'b0;
  logic        hold_request = 1'b0;
  logic        rx_quiet = 1'b0;
  bit          tx_quiet = 1'b0;
  int unsigned rx_stall = 0;
  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned local_cnt = 0;
  int unsigned directed_cnt = 0;
  int unsigned mismatches, pending, results, summer_seen;

  always #10 clk = ~clk;

  cet_summer_time_offset dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .timestamp_seconds_i(timestamp_seconds),
    .mode_i             (mode),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .offset_hours_o     (offset_hours),
    .summer_time_o      (summer_time)
  );

  cet_summer_time_offset_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .timestamp_seconds_i(timestamp_seconds),
    .mode_i             (mode),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .offset_hours_i     (offset_hours),
    .summer_time_i      (summer_time),
    .mismatches_o       (mismatches),
    .pending_o          (pending),
    .results_o          (results),
    .summer_results_o   (summer_seen)
  );

  // Stall the output a random number of cycles after each item
  always @(posedge clk) begin : receive
    int unsigned s;
    s = rx_stall;
    if (out_valid && out_ready) s = rx_quiet ? 0 : $urandom_range(0, 16);
    else if (s != 0) s--;
    rx_stall  <= s;
    out_ready <= (s == 0) && !hold_off;
  end

  // Hold the output off for a long stretch so the pipeline backs up
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Day count of January 1st of a year
  function automatic longint new_year_day(int yr);
    return 365 * longint'(yr - 1970) + (yr - 1969) / 4 - ((yr > 2100) ? 1 : 0);
  endfunction

  // Epoch second of a summer time switch instant
  function automatic longint bound_secs(int yr, bound_e kind);
    longint d31, hour;
    int     leap;
    leap = ((yr % 4) == 0 && yr != 2100) ? 1 : 0;
    d31  = new_year_day(yr) + leap +
           ((kind == SpringUtc || kind == SpringLocal) ? 89 : 303);
    case (kind)
      SpringLocal: hour = 7200;
      AutumnLocal: hour = 10800;
      default:     hour = 3600;
    endcase
    return (d31 - (d31 + 4) % 7) * DaySecs + hour;
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(longint secs, logic m);
    int unsigned gap;
    if (secs < 0 || secs > MaxStamp) secs = $urandom;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    timestamp_seconds <= secs[31:0];
    mode              <= m;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    if (m) local_cnt++;
  endtask

  initial begin
    bound_e      kind;
    int          yr;
    longint      delta;
    int unsigned pick;
    logic        m;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Range ends in both modes
    send_item(0, 1'b0);
    send_item(0, 1'b1);
    send_item(MaxStamp, 1'b0);
    send_item(MaxStamp, 1'b1);
    // Each switch instant and the second before it
    for (int k = 0; k < 4; k++) begin
      kind = bound_e'(k);
      send_item(bound_secs(2024, kind) - 1, kind >= SpringLocal);
      send_item(bound_secs(2024, kind), kind >= SpringLocal);
    end
    send_item(bound_secs(1970, SpringUtc) - 1, 1'b0);
    send_item(bound_secs(1970, SpringUtc), 1'b0);
    send_item(bound_secs(2100, AutumnLocal) - 1, 1'b1);
    send_item(bound_secs(2100, AutumnLocal), 1'b1);
    send_item(bound_secs(2105, AutumnLocal), 1'b1);
    // New-year edges, the last one into 2106
    send_item(new_year_day(2000) * DaySecs - 1, 1'b0);
    send_item(new_year_day(2000) * DaySecs, 1'b0);
    send_item(new_year_day(2106) * DaySecs - 1, 1'b0);
    send_item(new_year_day(2106) * DaySecs, 1'b1);
    directed_cnt = sent_cnt;

    // Random items, weighted toward switch instants and year edges
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet <= ($urandom_range(0, 3) == 0);
      end
      if (i == 200) begin
        tx_quiet = 1'b1;
        hold_request <= 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        kind = bound_e'($urandom_range(0, 3));
        yr   = $urandom_range(1970, 2105);
        case ($urandom_range(0, 3))
          0:       delta = 0;
          1:       delta = -1;
          2:       delta = longint'($urandom_range(0, 14400)) - 7200;
          default: delta = longint'($urandom_range(0, 6 * 86400)) - 3 * 86400;
        endcase
        m = ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1))
                                        : (kind >= SpringLocal);
        send_item(bound_secs(yr, kind) + delta, m);
      end else if (pick < 55) begin
        yr    = $urandom_range(1971, 2106);
        delta = longint'($urandom_range(0, 4 * 86400)) - 2 * 86400;
        send_item(new_year_day(yr) * DaySecs + delta, 1'($urandom_range(0, 1)));
      end else begin
        send_item($urandom, 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;

    // Drain the pipeline
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d timestamps (%0d directed, %0d local-time) against %0d results,",
             sent_cnt, directed_cnt, local_cnt, results);
    $display("%0d in summer time; switch instants, year edges, 2106 and a long stall hit.",
             summer_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
